### hdl/rds_pkg.sv
// Shared types, constants and helpers of the datagram session reliability block.
package rds_pkg;

  localparam int QUEUE_DEPTH   = 16;
  localparam int RECV_SEQ_BITS = 16;
  localparam int MAX_OUT       = 16;

  localparam int SEQ_W  = 15;
  localparam int QIW    = $clog2(QUEUE_DEPTH);
  localparam int QCW    = $clog2(QUEUE_DEPTH + 1);
  localparam int VW     = $clog2(MAX_OUT + 1);

  // seen-sequence bitmap: rows of SEEN_WORD bits
  localparam int SEEN_WORD = 16;
  localparam int SEEN_BW   = $clog2(SEEN_WORD);
  localparam int SEEN_ROWS = (1 << RECV_SEQ_BITS) / SEEN_WORD;
  localparam int ROW_W     = RECV_SEQ_BITS - SEEN_BW;

  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 64;
  localparam int CFG_AW     = 4;

  localparam logic [1:0] REG_SESSION_ID   = 2'd0;
  localparam logic [1:0] REG_START_SEQ    = 2'd1;
  localparam logic [1:0] REG_RETRY_TICKS  = 2'd2;
  localparam logic [1:0] REG_MAX_ATTEMPTS = 2'd3;

  localparam logic [15:0] CMD_ACK    = 16'd1;
  localparam logic [15:0] CMD_PING   = 16'd2;
  localparam logic [15:0] CMD_SIGNON = 16'd4;
  localparam logic [3:0]  TRIES_MAX  = 4'hf;

  typedef enum logic [1:0] {
    OP_TX      = 2'd0,
    OP_RECV    = 2'd1,
    OP_TICK    = 2'd2,
    OP_RESTART = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    KIND_TX         = 4'd0,
    KIND_SEND_ACK   = 4'd1,
    KIND_DELIVER    = 4'd2,
    KIND_DUPLICATE  = 4'd3,
    KIND_BAD_SESS   = 4'd4,
    KIND_ACKED      = 4'd5,
    KIND_ACK_IGN    = 4'd6,
    KIND_RESEND     = 4'd7,
    KIND_CONN_FAIL  = 4'd8,
    KIND_SEND_FAIL  = 4'd9,
    KIND_QUEUE_FULL = 4'd10,
    KIND_RESTARTED  = 4'd11
  } kind_t;

  typedef enum logic [2:0] {
    CLS_TX,
    CLS_RX_BAD,
    CLS_RX_ACK,
    CLS_RX_DATA,
    CLS_TICK,
    CLS_RESTART
  } cls_t;

  typedef struct packed {
    cls_t        cls;
    logic [15:0] seq;
    logic [15:0] cmd;
    logic [31:0] clients;
    logic        no_retry;
  } cmd_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] seq;
    logic [15:0] cmd;
    logic [31:0] clients;
    logic        last;
  } res_t;

  typedef struct packed {
    logic clearing;
  } stat_t;

  function automatic res_t mk_res(input kind_t k, input logic [15:0] s,
                                  input logic [15:0] c, input logic [31:0] n,
                                  input logic l);
    res_t r;
    r.kind    = k;
    r.seq     = s;
    r.cmd     = c;
    r.clients = n;
    r.last    = l;
    return r;
  endfunction

  // wrap-safe: expired when expiry - now is zero or negative
  function automatic logic expired(input logic [31:0] exp, input logic [31:0] now);
    logic [31:0] d;
    d = exp - now;
    return (d == 32'd0) || d[31];
  endfunction

endpackage

### hdl/rds_ram.sv
// Generic single-port-write, registered-read RAM.
module rds_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

### hdl/rds_front.sv
// Front end: takes input requests, checks the session and classifies them.
module rds_front (
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [rds_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic [1:0]                         in_tuser,
  input  logic [31:0]                        session_id,
  input  logic                               q_full,
  input  rds_pkg::stat_t                     stat,
  output logic                               push,
  output rds_pkg::cmd_t                      push_cmd
);
  import rds_pkg::*;

  logic [31:0] sess;
  op_t         op;

  assign sess      = in_tdata[31:0];
  assign op        = op_t'(in_tuser);
  assign in_tready = !q_full && !stat.clearing;
  assign push      = in_tvalid && in_tready;

  always_comb begin
    push_cmd.seq      = in_tdata[47:32];
    push_cmd.cmd      = in_tdata[63:48];
    push_cmd.clients  = in_tdata[95:64];
    push_cmd.no_retry = in_tdata[96];
    case (op)
      OP_TX:   push_cmd.cls = CLS_TX;
      OP_RECV: begin
        if (sess != session_id) push_cmd.cls = CLS_RX_BAD;
        else if (in_tdata[63:48] == CMD_ACK) push_cmd.cls = CLS_RX_ACK;
        else push_cmd.cls = CLS_RX_DATA;
      end
      OP_TICK: push_cmd.cls = CLS_TICK;
      default: push_cmd.cls = CLS_RESTART;
    endcase
  end
endmodule

### hdl/rds_cmdq.sv
// Two-entry command queue between the front end and the engine.
module rds_cmdq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rds_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output rds_pkg::cmd_t head
);
  import rds_pkg::*;

  cmd_t       ent_r [2];
  logic       rd_r;
  logic       wr_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign head  = ent_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        ent_r[wr_r] <= push_cmd;
        wr_r        <= !wr_r;
      end
      if (pop) begin
        rd_r <= !rd_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

### hdl/rds_back.sv
// Engine: retransmission queue, seen-sequence bitmap and result register.
module rds_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [14:0]                   start_seq,
  input  logic [15:0]                   retry_ticks,
  input  logic [3:0]                    max_attempts,
  input  logic                          cq_valid,
  input  rds_pkg::cmd_t                 cq_head,
  output logic                          cq_pop,
  output rds_pkg::stat_t                stat,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [rds_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [3:0]                    out_tuser,
  output logic                          out_tlast
);
  import rds_pkg::*;

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_TX, ST_TX_FULL, ST_ACK, ST_RX_DATA, ST_RX_CHK,
    ST_TICK, ST_EMIT
  } state_t;

  state_t            state_r;
  cmd_t              cur_r;
  logic [SEQ_W-1:0]  q_seq_r   [QUEUE_DEPTH];
  logic [15:0]       q_cmd_r   [QUEUE_DEPTH];
  logic [31:0]       q_exp_r   [QUEUE_DEPTH];
  logic [3:0]        q_tries_r [QUEUE_DEPTH];
  logic [QCW-1:0]    q_cnt_r;
  logic [SEQ_W-1:0]  send_seq_r;
  logic [31:0]       now_r;
  logic [31:0]       clients_r;
  logic [QCW-1:0]    srch_r;
  logic [VW-1:0]     vleft_r;
  logic [ROW_W-1:0]  clr_row_r;
  logic              clr_emit_r;
  res_t              res_r;
  logic              out_valid_r;
  res_t              out_res_r;

  logic              can_emit;
  logic              emit_go;
  logic              tick_stop;
  logic [SEQ_W-1:0]  seq_inc;
  logic [31:0]       new_exp;
  logic              q_full;
  logic [QCW-1:0]    cnt_m1;
  logic [QIW-1:0]    tail_idx;
  logic [QIW-1:0]    push_idx;
  logic [QIW-1:0]    srch_idx;
  logic              srch_hit;
  logic [3:0]        t_inc;
  logic              t_fail;
  kind_t             fail_kind;
  logic              head_exp;
  logic              next_exists;
  logic [31:0]       next_exp;
  logic              tick_last;
  logic              seen_bit;
  logic              ram_we;
  logic [ROW_W-1:0]  ram_waddr;
  logic [SEEN_WORD-1:0] ram_wdata;
  logic              ram_re;
  logic [SEEN_WORD-1:0] ram_rdata;
  logic [SEEN_WORD-1:0] bit_mask;
  logic [ROW_W-1:0]  cur_row;

  assign can_emit  = !out_valid_r || out_tready;
  assign seq_inc   = send_seq_r + SEQ_W'(1);
  assign new_exp   = now_r + 32'(retry_ticks);
  assign q_full    = (q_cnt_r == QCW'(QUEUE_DEPTH));
  assign cnt_m1    = q_cnt_r - QCW'(1);
  assign tail_idx  = cnt_m1[QIW-1:0];
  assign push_idx  = q_cnt_r[QIW-1:0];
  assign srch_idx  = srch_r[QIW-1:0];
  assign srch_hit  = ({1'b0, q_seq_r[srch_idx]} == cur_r.seq);

  assign t_inc     = (q_tries_r[0] == TRIES_MAX) ? TRIES_MAX : q_tries_r[0] + 4'd1;
  assign t_fail    = (t_inc >= max_attempts);
  assign fail_kind = (q_cmd_r[0] == CMD_PING || q_cmd_r[0] == CMD_SIGNON) ?
                     KIND_CONN_FAIL : KIND_SEND_FAIL;
  assign head_exp  = expired(q_exp_r[0], now_r);
  assign tick_stop = (vleft_r == '0) || (q_cnt_r == '0) || !head_exp;
  // what the head will be after this entry leaves (and maybe re-enters)
  assign next_exists = (q_cnt_r > QCW'(1)) || !t_fail;
  assign next_exp    = (q_cnt_r > QCW'(1)) ? q_exp_r[1] : new_exp;
  assign tick_last   = (vleft_r == VW'(1)) || !next_exists || !expired(next_exp, now_r);

  assign emit_go = can_emit &&
                   ((state_r == ST_TX) || (state_r == ST_TX_FULL) ||
                    (state_r == ST_RX_DATA) || (state_r == ST_RX_CHK) ||
                    (state_r == ST_EMIT) || ((state_r == ST_TICK) && !tick_stop));

  assign cur_row   = cur_r.seq[RECV_SEQ_BITS-1:SEEN_BW];
  assign seen_bit  = ram_rdata[cur_r.seq[SEEN_BW-1:0]];
  assign bit_mask  = SEEN_WORD'(1) << cur_r.seq[SEEN_BW-1:0];
  assign ram_re    = (state_r == ST_RX_DATA);
  assign ram_we    = (state_r == ST_CLR) ||
                     ((state_r == ST_RX_CHK) && can_emit && !seen_bit);
  assign ram_waddr = (state_r == ST_CLR) ? clr_row_r : cur_row;
  assign ram_wdata = (state_r == ST_CLR) ? '0 : (ram_rdata | bit_mask);

  assign cq_pop        = (state_r == ST_IDLE) && cq_valid;
  assign stat.clearing = (state_r == ST_CLR);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.clients, out_res_r.cmd, out_res_r.seq};
  assign out_tuser  = out_res_r.kind;
  assign out_tlast  = out_res_r.last;

  rds_ram #(.WIDTH(SEEN_WORD), .DEPTH(SEEN_ROWS)) u_seen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (cur_row),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_row_r   <= '0;
      clr_emit_r  <= 1'b0;
      q_cnt_r     <= '0;
      send_seq_r  <= '0;
      now_r       <= '0;
      clients_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit_go || (out_valid_r && !out_tready);
      case (state_r)
        ST_CLR: begin
          clr_row_r <= clr_row_r + ROW_W'(1);
          if (clr_row_r == ROW_W'(SEEN_ROWS - 1)) begin
            state_r <= clr_emit_r ? ST_EMIT : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cq_valid) begin
            cur_r <= cq_head;
            case (cq_head.cls)
              CLS_TX:      state_r <= ST_TX;
              CLS_RX_BAD: begin
                res_r   <= mk_res(KIND_BAD_SESS, cq_head.seq, cq_head.cmd, 32'd0, 1'b1);
                state_r <= ST_EMIT;
              end
              CLS_RX_ACK: begin
                srch_r  <= '0;
                state_r <= ST_ACK;
              end
              CLS_RX_DATA: state_r <= ST_RX_DATA;
              CLS_TICK: begin
                now_r   <= now_r + 32'd1;
                vleft_r <= (32'(q_cnt_r) > MAX_OUT) ? VW'(MAX_OUT) : VW'(q_cnt_r);
                state_r <= ST_TICK;
              end
              default: begin
                q_cnt_r    <= '0;
                clients_r  <= '0;
                send_seq_r <= start_seq;
                res_r      <= mk_res(KIND_RESTARTED, {1'b0, start_seq}, 16'd0,
                                     32'd0, 1'b1);
                clr_emit_r <= 1'b1;
                clr_row_r  <= '0;
                state_r    <= ST_CLR;
              end
            endcase
          end
        end
        ST_TX: begin
          if (can_emit) begin
            send_seq_r  <= seq_inc;
            out_res_r   <= mk_res(KIND_TX, {1'b0, seq_inc}, cur_r.cmd, 32'd0,
                                  cur_r.no_retry || !q_full);
            if (!cur_r.no_retry && !q_full) begin
              q_seq_r[push_idx]   <= seq_inc;
              q_cmd_r[push_idx]   <= cur_r.cmd;
              q_exp_r[push_idx]   <= new_exp;
              q_tries_r[push_idx] <= 4'd0;
              q_cnt_r             <= q_cnt_r + QCW'(1);
            end
            state_r <= (!cur_r.no_retry && q_full) ? ST_TX_FULL : ST_IDLE;
          end
        end
        ST_TX_FULL: begin
          if (can_emit) begin
            out_res_r   <= mk_res(KIND_QUEUE_FULL, {1'b0, send_seq_r}, cur_r.cmd,
                                  32'd0, 1'b1);
            state_r     <= ST_IDLE;
          end
        end
        ST_ACK: begin
          if (srch_r == q_cnt_r) begin
            res_r   <= mk_res(KIND_ACK_IGN, cur_r.seq, cur_r.cmd, 32'd0, 1'b1);
            state_r <= ST_EMIT;
          end else if (srch_hit) begin
            for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
              if (QCW'(j) >= srch_r) begin
                q_seq_r[j]   <= q_seq_r[j+1];
                q_cmd_r[j]   <= q_cmd_r[j+1];
                q_exp_r[j]   <= q_exp_r[j+1];
                q_tries_r[j] <= q_tries_r[j+1];
              end
            end
            q_cnt_r   <= cnt_m1;
            clients_r <= cur_r.clients;
            res_r     <= mk_res(KIND_ACKED, cur_r.seq, cur_r.cmd, cur_r.clients, 1'b1);
            state_r   <= ST_EMIT;
          end else begin
            srch_r <= srch_r + QCW'(1);
          end
        end
        ST_RX_DATA: begin
          // bitmap row read is issued here, checked in the next state
          if (can_emit) begin
            out_res_r   <= mk_res(KIND_SEND_ACK, cur_r.seq, CMD_ACK, 32'd0, 1'b0);
            state_r     <= ST_RX_CHK;
          end
        end
        ST_RX_CHK: begin
          if (can_emit) begin
            out_res_r   <= mk_res(seen_bit ? KIND_DUPLICATE : KIND_DELIVER,
                                  cur_r.seq, cur_r.cmd, 32'd0, 1'b1);
            state_r     <= ST_IDLE;
          end
        end
        ST_TICK: begin
          if (tick_stop) begin
            state_r <= ST_IDLE;
          end else if (can_emit) begin
            out_res_r   <= mk_res(t_fail ? fail_kind : KIND_RESEND, {1'b0, q_seq_r[0]},
                                  q_cmd_r[0], 32'd0, tick_last);
            // shift down; a resent entry lands in the tail slot instead
            for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
              if (t_fail || QIW'(j) != tail_idx) begin
                q_seq_r[j]   <= q_seq_r[j+1];
                q_cmd_r[j]   <= q_cmd_r[j+1];
                q_exp_r[j]   <= q_exp_r[j+1];
                q_tries_r[j] <= q_tries_r[j+1];
              end
            end
            if (!t_fail) begin
              q_seq_r[tail_idx]   <= q_seq_r[0];
              q_cmd_r[tail_idx]   <= q_cmd_r[0];
              q_exp_r[tail_idx]   <= new_exp;
              q_tries_r[tail_idx] <= t_inc;
            end else begin
              q_cnt_r <= cnt_m1;
            end
            vleft_r <= vleft_r - VW'(1);
            if (tick_last) begin
              state_r <= ST_IDLE;
            end
          end
        end
        ST_EMIT: begin
          if (can_emit) begin
            out_res_r   <= res_r;
            clr_emit_r  <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end
endmodule

### hdl/reliable_datagram_session.sv
// Top level: config registers, front end, command queue and engine.
// An ack search scans the retransmission queue one entry a cycle; a tick resends
//   or fails one expired entry a cycle while the output is not stalled.
// The engine takes a new request only once it is through with the last one;
//   an unmatched ack walks all of the retransmission queue (up to 16 entries).
// Reset and restart each run a pass over all 4096 rows that zeroes the seen-sequence
//   bitmap RAM, one row a cycle; no request is taken meanwhile.
module reliable_datagram_session (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // pkt_session[31:0], pkt_seq[47:32], pkt_cmd[63:48], ack_clients[95:64],
  // no_retry[96], zero fill
  input  logic [rds_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic [1:0]                    in_tuser,   // opcode
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // out_seq[15:0], out_cmd[31:16], client_count[63:32]
  output logic [rds_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [3:0]                    out_tuser,  // kind
  output logic                          out_tlast,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [rds_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);
  import rds_pkg::*;

  logic [31:0] session_id_r;
  logic [14:0] start_seq_r;
  logic [15:0] retry_ticks_r;
  logic [3:0]  max_attempts_r;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  logic  push;
  cmd_t  push_cmd;
  logic  cq_full;
  logic  cq_valid;
  cmd_t  cq_head;
  logic  cq_pop;
  stat_t stat;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      session_id_r   <= 32'd0;
      start_seq_r    <= 15'd0;
      retry_ticks_r  <= 16'd10;
      max_attempts_r <= 4'd5;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SESSION_ID:   session_id_r   <= cfg_pwdata;
        REG_START_SEQ:    start_seq_r    <= cfg_pwdata[14:0];
        REG_RETRY_TICKS:  retry_ticks_r  <= cfg_pwdata[15:0];
        REG_MAX_ATTEMPTS: max_attempts_r <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SESSION_ID:   cfg_prdata = session_id_r;
      REG_START_SEQ:    cfg_prdata = {17'd0, start_seq_r};
      REG_RETRY_TICKS:  cfg_prdata = {16'd0, retry_ticks_r};
      REG_MAX_ATTEMPTS: cfg_prdata = {28'd0, max_attempts_r};
      default:          cfg_prdata = 32'd0;
    endcase
  end

  rds_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .session_id (session_id_r),
    .q_full     (cq_full),
    .stat       (stat),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  rds_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (cq_full),
    .pop      (cq_pop),
    .valid    (cq_valid),
    .head     (cq_head)
  );

  rds_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .start_seq    (start_seq_r),
    .retry_ticks  (retry_ticks_r),
    .max_attempts (max_attempts_r),
    .cq_valid     (cq_valid),
    .cq_head      (cq_head),
    .cq_pop       (cq_pop),
    .stat         (stat),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast)
  );
endmodule

### hdl/rds_checker.sv
// Port-level checks on the session block, bound to the top level.
module rds_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [rds_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [3:0]                    out_tuser,
  input logic                          out_tlast
);
  import rds_pkg::*;

  // bitmap clearing follows reset, so no request straight after it
  a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !in_tready)
    else $error("request taken during bitmap clear");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_ack_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_SEND_ACK |-> !out_tlast)
    else $error("send ack must be followed by deliver or duplicate");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_RESTARTED || out_tuser == KIND_QUEUE_FULL ||
                   out_tuser == KIND_ACKED || out_tuser == KIND_DELIVER) |-> out_tlast)
    else $error("final result without last");

  a_clients_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_ACKED |-> out_tdata[63:32] == 32'd0)
    else $error("client count on a result other than acked");
endmodule

bind reliable_datagram_session rds_checker u_rds_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
